[sv/assert_macros.svh]
// Assertion macros for the RTL of the instruction check block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge of i_clk outside reset
`define AICS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising edge of i_clk outside reset
`define AICS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/aics_pkg.sv]
// Package: opcodes, format groups, field shuffles and legality lists
`default_nettype none

package aics_pkg;

    // Major opcodes (bits 31..26) that get special handling
    localparam logic [5:0] OP_PAL  = 6'h00;
    localparam logic [5:0] OP_INTA = 6'h10;
    localparam logic [5:0] OP_INTL = 6'h11;
    localparam logic [5:0] OP_INTS = 6'h12;
    localparam logic [5:0] OP_INTM = 6'h13;
    localparam logic [5:0] OP_ITFP = 6'h14;
    localparam logic [5:0] OP_FLTV = 6'h15;
    localparam logic [5:0] OP_FLTI = 6'h16;
    localparam logic [5:0] OP_FLTL = 6'h17;
    localparam logic [5:0] OP_MISC = 6'h18;
    localparam logic [5:0] OP_FPTI = 6'h1C;

    // Direction register codes
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_INV = 1'b1;

    localparam logic DIRECTION_RESET = DIR_FWD;

    // Field layout group of an opcode
    typedef enum logic [1:0] {
        GRP_NONE  = 2'd0,
        GRP_FPOP  = 2'd1,
        GRP_MISC  = 2'd2,
        GRP_INTOP = 2'd3
    } t_group;

    function automatic t_group f_group(input logic [5:0] op);
        t_group g;
        unique case (op)
            OP_ITFP, OP_FLTV, OP_FLTI, OP_FLTL: g = GRP_FPOP;
            OP_MISC:                            g = GRP_MISC;
            OP_INTA, OP_INTL, OP_INTS, OP_INTM,
            OP_FPTI:                            g = GRP_INTOP;
            default:                            g = GRP_NONE;
        endcase
        return g;
    endfunction

    function automatic logic [31:0] f_swap_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    // Move op and func to the top of the word
    function automatic logic [31:0] f_fwd_fields(input logic [31:0] w);
        logic [31:0] r;
        unique case (f_group(w[31:26]))
            GRP_FPOP:  r = {w[31:26], w[15:5], w[25:16], w[4:0]};
            GRP_MISC:  r = {w[31:26], w[15:0], w[25:16]};
            GRP_INTOP: r = {w[31:26], w[12:5], w[25:13], w[4:0]};
            default:   r = w;
        endcase
        return r;
    endfunction

    // Restore the original field order
    function automatic logic [31:0] f_inv_fields(input logic [31:0] w);
        logic [31:0] r;
        unique case (f_group(w[31:26]))
            GRP_FPOP:  r = {w[31:26], w[14:5], w[25:15], w[4:0]};
            GRP_MISC:  r = {w[31:26], w[9:0], w[25:10]};
            GRP_INTOP: r = {w[31:26], w[17:5], w[25:18], w[4:0]};
            default:   r = w;
        endcase
        return r;
    endfunction

    // Legal function code lists
    function automatic logic f_int_add(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h40, 7'h00, 7'h02, 7'h49, 7'h09, 7'h0B, 7'h0F, 7'h12, 7'h1B, 7'h1D,
            7'h60, 7'h20, 7'h22, 7'h69, 7'h29, 7'h2B, 7'h2D, 7'h32, 7'h3B, 7'h3D,
            7'h4D, 7'h6D: ok = 1'b1;
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_int_log(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h00, 7'h08, 7'h14, 7'h16, 7'h20, 7'h24, 7'h26, 7'h28, 7'h40, 7'h44,
            7'h46, 7'h48, 7'h61, 7'h64, 7'h66, 7'h6C: ok = 1'b1;
            default:                                  ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_int_sh(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h02, 7'h06, 7'h0B, 7'h12, 7'h16, 7'h1B, 7'h22, 7'h26, 7'h2B, 7'h30,
            7'h31, 7'h32, 7'h34, 7'h36, 7'h39, 7'h3B, 7'h3C, 7'h52, 7'h57, 7'h5A,
            7'h62, 7'h67, 7'h6A, 7'h72, 7'h77, 7'h7A: ok = 1'b1;
            default:                                  ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_int_mul(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h40, 7'h00, 7'h60, 7'h20, 7'h30: ok = 1'b1;
            default:                           ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_itof(input logic [10:0] f);
        logic ok;
        unique case (f)
            11'h004, 11'h00A, 11'h08A, 11'h10A, 11'h18A, 11'h40A, 11'h48A, 11'h50A,
            11'h58A, 11'h00B, 11'h04B, 11'h08B, 11'h0CB, 11'h10B, 11'h14B, 11'h18B,
            11'h1CB, 11'h50B, 11'h54B, 11'h58B, 11'h5CB, 11'h70B, 11'h74B, 11'h78B,
            11'h7CB, 11'h014, 11'h024, 11'h02A, 11'h0AA, 11'h12A, 11'h1AA, 11'h42A,
            11'h4AA, 11'h52A, 11'h5AA, 11'h02B, 11'h06B, 11'h0AB, 11'h0EB, 11'h12B,
            11'h16B, 11'h1AB, 11'h1EB, 11'h52B, 11'h56B, 11'h5AB, 11'h5EB, 11'h72B,
            11'h76B, 11'h7AB, 11'h7EB: ok = 1'b1;
            default:                   ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_vax_a(input logic [10:0] f);
        logic ok;
        unique case (f)
            11'h0A5, 11'h4A5, 11'h0A6, 11'h4A6, 11'h0A7, 11'h4A7, 11'h03C, 11'h0BC,
            11'h03E, 11'h0BE: ok = 1'b1;
            default:          ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_vax_b(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h00, 7'h01, 7'h02, 7'h03, 7'h1E, 7'h20, 7'h21, 7'h22, 7'h23, 7'h2C,
            7'h2D, 7'h2F: ok = 1'b1;
            default:      ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_ieee_a(input logic [10:0] f);
        logic ok;
        unique case (f)
            11'h0A4, 11'h5A4, 11'h0A5, 11'h5A5, 11'h0A6, 11'h5A6, 11'h0A7, 11'h5A7,
            11'h2AC, 11'h6AC: ok = 1'b1;
            default:          ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_ieee_b(input logic [5:0] f);
        logic ok;
        unique case (f)
            6'h00, 6'h01, 6'h02, 6'h03, 6'h20, 6'h21, 6'h22, 6'h23, 6'h2C,
            6'h2F:   ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_fpl(input logic [10:0] f);
        logic ok;
        unique case (f)
            11'h010, 11'h020, 11'h021, 11'h022, 11'h024, 11'h025, 11'h02A, 11'h02B,
            11'h02C, 11'h02D, 11'h02E, 11'h02F, 11'h030, 11'h130,
            11'h530: ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_misc(input logic [15:0] f);
        logic ok;
        unique case (f)
            16'h0000, 16'h0400, 16'h4000, 16'h4400, 16'h8000, 16'hA000, 16'hC000,
            16'hE000, 16'hE800, 16'hF000, 16'hF800, 16'hFC00: ok = 1'b1;
            default:                                          ok = 1'b0;
        endcase
        return ok;
    endfunction

    function automatic logic f_ftoi(input logic [6:0] f);
        logic ok;
        unique case (f)
            7'h00, 7'h01, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
            7'h38, 7'h39, 7'h3A, 7'h3B, 7'h3C, 7'h3D, 7'h3E, 7'h3F, 7'h70,
            7'h78:   ok = 1'b1;
            default: ok = 1'b0;
        endcase
        return ok;
    endfunction

    // IEEE FP group: list A, then the rounding/trap masking rules
    function automatic logic f_ieee_legal(input logic [10:0] f);
        logic ok;
        if (f_ieee_a(f)) begin
            ok = 1'b1;
        end else if (f[10:9] == 2'b01 || (f[10] && !f[8])) begin
            ok = 1'b0;
        end else if (f_ieee_b(f[5:0])) begin
            ok = 1'b1;
        end else if (f[5:0] == 6'h3C || f[5:0] == 6'h3E) begin
            ok = (f[9:8] != 2'b01);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    // Legality of a word in original field order
    function automatic logic f_legal_word(input logic [31:0] w);
        logic [5:0]  op;
        logic [6:0]  f7;
        logic [10:0] f11;
        logic        ok;
        op  = w[31:26];
        f7  = w[11:5];
        f11 = w[15:5];
        unique case (op)
            // PAL: low bits in 0x00..0x3F or 0x80..0xBF
            OP_PAL:  ok = (w[28:8] == 21'd0) && !w[6];
            OP_INTA: ok = f_int_add(f7);
            OP_INTL: ok = f_int_log(f7);
            OP_INTS: ok = f_int_sh(f7);
            OP_INTM: ok = f_int_mul(f7);
            OP_ITFP: ok = f_itof(f11);
            OP_FLTV: ok = f_vax_a(f11) || (!f11[9] && f_vax_b(f11[6:0]));
            OP_FLTI: ok = f_ieee_legal(f11);
            OP_FLTL: ok = f_fpl(f11);
            OP_MISC: ok = f_misc(w[15:0]);
            OP_FPTI: ok = f_ftoi(f7);
            // reserved opcodes 0x01..0x07 are illegal, all others legal
            default: ok = (op[5:3] != 3'd0);
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

[sv/alpha_instruction_check_and_shuffle.sv]
// Top level: instruction legality check with field shuffle and byte swap
//
//  channel | signals                              | handshake
//  --------+--------------------------------------+-----------------------
//  input   | i_instr_word                         | i_valid / o_ready
//  output  | o_out_word, o_is_legal               | o_valid / i_ready
//  config  | i_cfg_data (direction)               | i_cfg_we, no wait
//
// One item per cycle while i_ready is high; an accepted item goes to the input
// register, then check and shuffle logic into the result register (o_valid).
// Reset (synchronous, active low) empties both stages and sets forward direction.
// A stall on i_ready holds the result; the input register still fills, so one
// item more is taken before o_ready drops.
`default_nettype none

module alpha_instruction_check_and_shuffle (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_instr_word,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [31:0]      o_out_word,
    output logic             o_is_legal,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_data
);

`include "assert_macros.svh"

    logic        r_direction;
    logic        r_s1_valid;
    logic [31:0] r_s1_word;
    logic        r_out_valid;
    logic [31:0] r_out_word;
    logic        r_out_legal;

    logic        s1_advance;
    logic        in_take;
    logic [31:0] n_out_word;
    logic        n_out_legal;
    logic [31:0] fwd_word;
    logic [31:0] inv_word;
    logic        out_fwd_reserved;

    // Handshake: result register frees, then input register frees
    assign s1_advance = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready    = !r_s1_valid || s1_advance;
    assign in_take    = i_valid && o_ready;

    // Direction register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= aics_pkg::DIRECTION_RESET;
        end else if (i_cfg_we) begin
            r_direction <= i_cfg_data;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_ready) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_word <= i_instr_word;
        end
    end

    // Shuffle and check; legality always taken on the original field order
    assign fwd_word = aics_pkg::f_swap_bytes(aics_pkg::f_fwd_fields(r_s1_word));
    assign inv_word = aics_pkg::f_inv_fields(aics_pkg::f_swap_bytes(r_s1_word));

    always_comb begin
        if (r_direction == aics_pkg::DIR_INV) begin
            n_out_word  = inv_word;
            n_out_legal = aics_pkg::f_legal_word(inv_word);
        end else begin
            n_out_word  = fwd_word;
            n_out_legal = aics_pkg::f_legal_word(r_s1_word);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_advance) begin
            r_out_word  <= n_out_word;
            r_out_legal <= n_out_legal;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_out_word = r_out_word;
    assign o_is_legal = r_out_legal;

    // Forward result whose opcode (low byte after the swap) is in 0x01..0x07
    assign out_fwd_reserved = r_out_valid && r_direction == aics_pkg::DIR_FWD &&
                              o_out_word[7:5] == 3'd0 && o_out_word[4:2] != 3'd0;

    // Checks
    `AICS_ASSERT_NEXT(a_take_fills_s1, in_take, r_s1_valid, "accepted item not in input register")
    `AICS_ASSERT_NEXT(a_advance_fills_out, s1_advance, r_out_valid, "advanced item lost")
    `AICS_ASSERT_NOW(a_fwd_reserved_illegal, out_fwd_reserved, !o_is_legal, "reserved opcode legal")

endmodule

`default_nettype wire

[dv/tb_top.sv]
// Testbench for the instruction legality check and field shuffle block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DRAIN_CYCLES   = 4;    // two pipeline stages plus margin
    localparam int STALL_CYCLES   = 80;   // long receiver hold-off that backs up the input
    localparam int WATCHDOG_LIMIT = 500;  // cycles with no item moving on either side
    localparam int SEGMENTS       = 6;
    localparam int SEGMENT_ITEMS  = 67;

    // One transformed word and its legality flag
    typedef struct packed {
        logic [31:0] word;
        logic        legal;
    } t_shuffle_result;

    // Directed stimulus row; expected values are used only when known is set
    typedef struct packed {
        logic        dir;
        logic [31:0] word;
        logic        known;
        logic [31:0] exp_word;
        logic        exp_legal;
    } t_directed_row;

    logic        i_clk        = 1'b0;
    logic        i_rst_n      = 1'b0;
    logic        i_valid      = 1'b0;
    logic [31:0] i_instr_word = '0;
    logic        i_ready      = 1'b0;
    logic        i_cfg_we     = 1'b0;
    logic        i_cfg_data   = aics_pkg::DIR_FWD;
    logic        o_ready;
    logic        o_valid;
    logic [31:0] o_out_word;
    logic        o_is_legal;

    t_shuffle_result expected_results[$];
    logic            dir_setting    = aics_pkg::DIRECTION_RESET;
    int              mismatch_count = 0;
    int              idle_cycles    = 0;
    bit              input_gaps_on  = 1'b1;
    bit              output_gaps_on = 1'b1;
    int              stall_requests = 0;
    int              stall_served   = 0;
    int              rx_hold_left   = 0;

    // Legal function codes per opcode group
    int unsigned int_add_codes[$] = '{'h40, 'h00, 'h02, 'h49, 'h09, 'h0B, 'h0F, 'h12, 'h1B,
                                      'h1D, 'h60, 'h20, 'h22, 'h69, 'h29, 'h2B, 'h2D, 'h32,
                                      'h3B, 'h3D, 'h4D, 'h6D};
    int unsigned int_log_codes[$] = '{'h00, 'h08, 'h14, 'h16, 'h20, 'h24, 'h26, 'h28, 'h40,
                                      'h44, 'h46, 'h48, 'h61, 'h64, 'h66, 'h6C};
    int unsigned int_sh_codes[$]  = '{'h02, 'h06, 'h0B, 'h12, 'h16, 'h1B, 'h22, 'h26, 'h2B,
                                      'h30, 'h31, 'h32, 'h34, 'h36, 'h39, 'h3B, 'h3C, 'h52,
                                      'h57, 'h5A, 'h62, 'h67, 'h6A, 'h72, 'h77, 'h7A};
    int unsigned int_mul_codes[$] = '{'h40, 'h00, 'h60, 'h20, 'h30};
    int unsigned itof_codes[$]    = '{'h004, 'h00A, 'h08A, 'h10A, 'h18A, 'h40A, 'h48A, 'h50A,
                                      'h58A, 'h00B, 'h04B, 'h08B, 'h0CB, 'h10B, 'h14B, 'h18B,
                                      'h1CB, 'h50B, 'h54B, 'h58B, 'h5CB, 'h70B, 'h74B, 'h78B,
                                      'h7CB, 'h014, 'h024, 'h02A, 'h0AA, 'h12A, 'h1AA, 'h42A,
                                      'h4AA, 'h52A, 'h5AA, 'h02B, 'h06B, 'h0AB, 'h0EB, 'h12B,
                                      'h16B, 'h1AB, 'h1EB, 'h52B, 'h56B, 'h5AB, 'h5EB, 'h72B,
                                      'h76B, 'h7AB, 'h7EB};
    int unsigned vax_full_codes[$]  = '{'h0A5, 'h4A5, 'h0A6, 'h4A6, 'h0A7, 'h4A7, 'h03C,
                                        'h0BC, 'h03E, 'h0BE};
    int unsigned vax_low_codes[$]   = '{'h00, 'h01, 'h02, 'h03, 'h1E, 'h20, 'h21, 'h22, 'h23,
                                        'h2C, 'h2D, 'h2F};
    int unsigned ieee_full_codes[$] = '{'h0A4, 'h5A4, 'h0A5, 'h5A5, 'h0A6, 'h5A6, 'h0A7,
                                        'h5A7, 'h2AC, 'h6AC};
    int unsigned ieee_low_codes[$]  = '{'h00, 'h01, 'h02, 'h03, 'h20, 'h21, 'h22, 'h23, 'h2C,
                                        'h2F};
    int unsigned fp_long_codes[$]   = '{'h010, 'h020, 'h021, 'h022, 'h024, 'h025, 'h02A,
                                        'h02B, 'h02C, 'h02D, 'h02E, 'h02F, 'h030, 'h130,
                                        'h530};
    int unsigned misc_codes[$]      = '{'h0000, 'h0400, 'h4000, 'h4400, 'h8000, 'hA000,
                                        'hC000, 'hE000, 'hE800, 'hF000, 'hF800, 'hFC00};
    int unsigned fp_to_int_codes[$] = '{'h00, 'h01, 'h30, 'h31, 'h32, 'h33, 'h34, 'h35, 'h36,
                                        'h37, 'h38, 'h39, 'h3A, 'h3B, 'h3C, 'h3D, 'h3E, 'h3F,
                                        'h70, 'h78};
    logic [5:0]  operate_ops[$] = '{aics_pkg::OP_INTA, aics_pkg::OP_INTL, aics_pkg::OP_INTS,
                                    aics_pkg::OP_INTM, aics_pkg::OP_ITFP, aics_pkg::OP_FLTV,
                                    aics_pkg::OP_FLTI, aics_pkg::OP_FLTL, aics_pkg::OP_MISC,
                                    aics_pkg::OP_FPTI};

    // Directed items: PAL range edges, reserved opcodes, every operate group with
    // legal or illegal functions, the FP masking rules, and both directions
    t_directed_row directed_rows [25] = '{
        '{aics_pkg::DIR_FWD, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{aics_pkg::DIR_FWD, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{aics_pkg::DIR_FWD, 32'h0400_0000, 1'b1, 32'h0000_0004, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h1C00_0000, 1'b1, 32'h0000_001C, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h0000_00BF, 1'b1, 32'hBF00_0000, 1'b1},
        '{aics_pkg::DIR_FWD, 32'h0000_0040, 1'b1, 32'h4000_0000, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h4000_0800, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h4400_0D80, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h4800_0F40, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h4C00_0620, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5000_FD60, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5400_94E0, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5400_45E0, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5400_25E0, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5800_4000, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5800_8000, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5800_1780, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5800_2780, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h5C00_A600, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h6000_FC00, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_FWD, 32'h7000_0F00, 1'b0, 32'h0, 1'b0},
        '{aics_pkg::DIR_INV, 32'h0000_0000, 1'b1, 32'h0000_0000, 1'b1},
        '{aics_pkg::DIR_INV, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 1'b1},
        '{aics_pkg::DIR_INV, 32'h0000_0004, 1'b1, 32'h0400_0000, 1'b0},
        '{aics_pkg::DIR_INV, 32'h0D00_4858, 1'b0, 32'h0, 1'b0}
    };

    alpha_instruction_check_and_shuffle u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_instr_word (i_instr_word),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_word   (o_out_word),
        .o_is_legal   (o_is_legal),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit on_list(input int unsigned codes[$], input int unsigned code);
        foreach (codes[i]) begin
            if (codes[i] == code) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic int unsigned pick_code(input int unsigned codes[$]);
        return codes[$urandom_range(0, codes.size() - 1)];
    endfunction

    function automatic aics_pkg::t_group layout_of(input logic [5:0] op);
        if (op >= aics_pkg::OP_ITFP && op <= aics_pkg::OP_FLTL) begin
            return aics_pkg::GRP_FPOP;
        end else if (op == aics_pkg::OP_MISC) begin
            return aics_pkg::GRP_MISC;
        end else if ((op >= aics_pkg::OP_INTA && op <= aics_pkg::OP_INTM) ||
                     op == aics_pkg::OP_FPTI) begin
            return aics_pkg::GRP_INTOP;
        end
        return aics_pkg::GRP_NONE;
    endfunction

    function automatic logic [31:0] byte_reverse(input logic [31:0] w);
        return {<<8{w}};
    endfunction

    // op and func move to the top of the word
    function automatic logic [31:0] shuffle_fields(input logic [31:0] w);
        case (layout_of(w[31:26]))
            aics_pkg::GRP_FPOP:  return (w & 32'hFC00_0000) | ((w & 32'hFFE0) << 10) |
                                        ((w >> 11) & 32'h7FE0) | (w & 32'h1F);
            aics_pkg::GRP_MISC:  return (w & 32'hFC00_0000) | ((w & 32'hFFFF) << 10) |
                                        ((w >> 16) & 32'h3FF);
            aics_pkg::GRP_INTOP: return (w & 32'hFC00_0000) | ((w << 13) & 32'h3FC_0000) |
                                        ((w >> 8) & 32'h3_FFE0) | (w & 32'h1F);
            default:             return w;
        endcase
    endfunction

    function automatic logic [31:0] unshuffle_fields(input logic [31:0] w);
        case (layout_of(w[31:26]))
            aics_pkg::GRP_FPOP:  return (w & 32'hFC00_0000) | ((w >> 10) & 32'hFFE0) |
                                        ((w & 32'h7FE0) << 11) | (w & 32'h1F);
            aics_pkg::GRP_MISC:  return (w & 32'hFC00_0000) | ((w >> 10) & 32'hFFFF) |
                                        ((w & 32'h3FF) << 16);
            aics_pkg::GRP_INTOP: return (w & 32'hFC00_0000) | ((w & 32'h3FC_0000) >> 13) |
                                        ((w & 32'h3_FFE0) << 8) | (w & 32'h1F);
            default:             return w;
        endcase
    endfunction

    // Legality of a word in original field order
    function automatic bit legal_encoding(input logic [31:0] w);
        logic [5:0]  op;
        logic [6:0]  f7;
        logic [10:0] f11;
        logic [28:0] pal_code;
        op       = w[31:26];
        f7       = w[11:5];
        f11      = w[15:5];
        pal_code = w[28:0];
        case (op)
            aics_pkg::OP_PAL:
                return pal_code <= 29'h3F || (pal_code >= 29'h80 && pal_code <= 29'hBF);
            aics_pkg::OP_INTA: return on_list(int_add_codes, f7);
            aics_pkg::OP_INTL: return on_list(int_log_codes, f7);
            aics_pkg::OP_INTS: return on_list(int_sh_codes, f7);
            aics_pkg::OP_INTM: return on_list(int_mul_codes, f7);
            aics_pkg::OP_ITFP: return on_list(itof_codes, f11);
            aics_pkg::OP_FLTV: return on_list(vax_full_codes, f11) ||
                                      (!f11[9] && on_list(vax_low_codes, f11[6:0]));
            aics_pkg::OP_FLTI: begin
                if (on_list(ieee_full_codes, f11)) begin
                    return 1'b1;
                end
                // rounding and trap qualifier combinations that are reserved
                if ((f11 & 11'h600) == 11'h200 || (f11 & 11'h500) == 11'h400) begin
                    return 1'b0;
                end
                if (on_list(ieee_low_codes, f11[5:0])) begin
                    return 1'b1;
                end
                if (f11[5:0] == 6'h3C || f11[5:0] == 6'h3E) begin
                    return (f11 & 11'h300) != 11'h100;
                end
                return 1'b0;
            end
            aics_pkg::OP_FLTL: return on_list(fp_long_codes, f11);
            aics_pkg::OP_MISC: return on_list(misc_codes, w[15:0]);
            aics_pkg::OP_FPTI: return on_list(fp_to_int_codes, f7);
            default:           return !(op >= 6'h01 && op <= 6'h07);
        endcase
    endfunction

    function automatic t_shuffle_result predict_shuffle(input logic [31:0] w, input logic dir);
        t_shuffle_result r;
        if (dir == aics_pkg::DIR_FWD) begin
            r.legal = legal_encoding(w);
            r.word  = byte_reverse(shuffle_fields(w));
        end else begin
            r.word  = unshuffle_fields(byte_reverse(w));
            r.legal = legal_encoding(r.word);
        end
        return r;
    endfunction

    // Original-order word, biased toward operate groups with legal functions
    function automatic logic [31:0] random_instruction();
        logic [31:0] w;
        int unsigned kind;
        w    = $urandom();
        kind = $urandom_range(0, 9);
        case (kind)
            0: begin
                if ($urandom_range(0, 1) == 0) begin
                    w = $urandom_range(0, 'hBF);
                end else begin
                    w[31:26] = aics_pkg::OP_PAL;
                end
            end
            1: w[31:26] = 6'($urandom_range(1, 7));
            2: ;
            default: begin
                w[31:26] = operate_ops[$urandom_range(0, operate_ops.size() - 1)];
                if ($urandom_range(0, 4) != 0) begin
                    case (w[31:26])
                        aics_pkg::OP_INTA: w[11:5] = 7'(pick_code(int_add_codes));
                        aics_pkg::OP_INTL: w[11:5] = 7'(pick_code(int_log_codes));
                        aics_pkg::OP_INTS: w[11:5] = 7'(pick_code(int_sh_codes));
                        aics_pkg::OP_INTM: w[11:5] = 7'(pick_code(int_mul_codes));
                        aics_pkg::OP_ITFP: w[15:5] = 11'(pick_code(itof_codes));
                        aics_pkg::OP_FLTV: begin
                            if ($urandom_range(0, 1) == 0) begin
                                w[15:5] = 11'(pick_code(vax_full_codes));
                            end else begin
                                w[11:5] = 7'(pick_code(vax_low_codes));
                            end
                        end
                        aics_pkg::OP_FLTI: begin
                            case ($urandom_range(0, 2))
                                0:       w[15:5] = 11'(pick_code(ieee_full_codes));
                                1:       w[10:5] = 6'(pick_code(ieee_low_codes));
                                default: w[10:5] = $urandom_range(0, 1) ? 6'h3C : 6'h3E;
                            endcase
                        end
                        aics_pkg::OP_FLTL: w[15:5] = 11'(pick_code(fp_long_codes));
                        aics_pkg::OP_MISC: w[15:0] = 16'(pick_code(misc_codes));
                        default:           w[11:5] = 7'(pick_code(fp_to_int_codes));
                    endcase
                end
            end
        endcase
        return w;
    endfunction

    // Shuffled-form word for inverse mode, mostly from a plausible original
    function automatic logic [31:0] random_shuffled_word();
        if ($urandom_range(0, 9) < 7) begin
            return byte_reverse(shuffle_fields(random_instruction()));
        end
        return $urandom();
    endfunction

    // Offer one item and record its expected result once it is taken
    task automatic offer_word(input logic [31:0] w, input t_shuffle_result want);
        bit taken;
        if (input_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_instr_word <= w;
        taken = 1'b0;
        while (!taken) begin
            @(negedge i_clk);
            taken = o_ready;
            @(posedge i_clk);
        end
        expected_results.push_back(want);
    endtask

    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Direction changes only once the pipeline is empty
    task automatic set_direction(input logic dir);
        i_valid <= 1'b0;
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= dir;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        dir_setting = dir;
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t ns: %s expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Receiver: random ready bursts, plus one long hold-off on request
    always @(posedge i_clk) begin
        if (stall_served != stall_requests) begin
            stall_served = stall_requests;
            rx_hold_left = STALL_CYCLES;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else if (output_gaps_on && $urandom_range(0, 5) == 0) begin
            rx_hold_left = $urandom_range(1, 14) - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Output check; values are stable at the falling edge ahead of the handshake
    always @(negedge i_clk) begin : check_output
        t_shuffle_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_results.size() == 0) begin
                note_mismatch("item with nothing pending, word", 32'h0, o_out_word);
            end else begin
                want = expected_results.pop_front();
                if (o_out_word !== want.word) begin
                    note_mismatch("out_word", want.word, o_out_word);
                end
                if (o_is_legal !== want.legal) begin
                    note_mismatch("is_legal", 32'(want.legal), 32'(o_is_legal));
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves
    always @(negedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        t_directed_row   row;
        t_shuffle_result want;
        logic [31:0]     w;
        logic            dir;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.dir != dir_setting) begin
                set_direction(row.dir);
            end
            want = predict_shuffle(row.word, dir_setting);
            if (row.known) begin
                want.word  = row.exp_word;
                want.legal = row.exp_legal;
            end
            offer_word(row.word, want);
        end

        // random segments, alternating direction; one long stall, quiet tail
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            dir = (seg % 2 == 0) ? aics_pkg::DIR_FWD : aics_pkg::DIR_INV;
            set_direction(dir);
            if (seg == 2) begin
                stall_requests++;
            end
            if (seg == SEGMENTS - 1) begin
                input_gaps_on  = 1'b0;
                output_gaps_on = 1'b0;
            end
            for (int k = 0; k < SEGMENT_ITEMS; k++) begin
                w = (dir == aics_pkg::DIR_FWD) ? random_instruction() : random_shuffled_word();
                offer_word(w, predict_shuffle(w, dir));
            end
        end

        i_valid <= 1'b0;
        drain_results();
        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
